// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked while out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/varu_pkg.sv =====
`default_nettype none
package varu_pkg;

    typedef enum logic [3:0] {
        MODE_ADD   = 4'd0,
        MODE_SUB   = 4'd1,
        MODE_NEG   = 4'd2,
        MODE_SCALE = 4'd3,
        MODE_DIV   = 4'd4,
        MODE_RDIV  = 4'd5,
        MODE_LEN   = 4'd6,
        MODE_SQLEN = 4'd7,
        MODE_NORM  = 4'd8,
        MODE_HOMOG = 4'd9,
        MODE_CMP   = 4'd10
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    // Squared length is held as unsigned Q17.16 in 33 bits.
    localparam int SQ_W       = 33;
    localparam logic [SQ_W-1:0] SQ_CAP = {SQ_W{1'b1}};
    // The square root works on the squared length shifted up by 16 bits.
    localparam int SQRT_IN_W  = 50;
    localparam int ROOT_W     = SQRT_IN_W / 2;
    localparam int REM_W      = ROOT_W + 2;
    localparam int FRAC_BITS  = 8;
    localparam int NORM_SHIFT = 16;

endpackage
`default_nettype wire

// ===== rtl/core/varu_sqrt_pipe.sv =====
`default_nettype none
// Pipelined integer square root, one result bit per stage.
module varu_sqrt_pipe
    import varu_pkg::*;
#(
    parameter int TAG_W = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_sq,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [TAG_W-1:0]  out_tag
);

    logic                 valid_reg [ROOT_W];
    logic [REM_W-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0]    root_reg  [ROOT_W];
    logic [SQRT_IN_W-1:0] data_reg  [ROOT_W];
    logic [TAG_W-1:0]     tag_reg   [ROOT_W];

    logic                 valid_cur [ROOT_W];
    logic [REM_W-1:0]     rem_cur   [ROOT_W];
    logic [ROOT_W-1:0]    root_cur  [ROOT_W];
    logic [SQRT_IN_W-1:0] data_cur  [ROOT_W];
    logic [TAG_W-1:0]     tag_cur   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_stage
        logic [REM_W+1:0]  part;
        logic [REM_W+1:0]  trial;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0)
        begin : g_first
            assign valid_cur[k] = in_valid;
            assign rem_cur[k]   = '0;
            assign root_cur[k]  = '0;
            assign data_cur[k]  = SQRT_IN_W'({in_sq, {NORM_SHIFT{1'b0}}});
            assign tag_cur[k]   = in_tag;
        end
        else
        begin : g_rest
            assign valid_cur[k] = valid_reg[k-1];
            assign rem_cur[k]   = rem_reg[k-1];
            assign root_cur[k]  = root_reg[k-1];
            assign data_cur[k]  = data_reg[k-1];
            assign tag_cur[k]   = tag_reg[k-1];
        end

        always_comb
        begin
            part  = {rem_cur[k], data_cur[k][SQRT_IN_W-1 -: 2]};
            trial = {{(REM_W-ROOT_W){1'b0}}, root_cur[k], 2'b01};
            if (part >= trial)
            begin
                rem_next  = REM_W'(part - trial);
                root_next = {root_cur[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(part);
                root_next = {root_cur[k][ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else
            begin
                valid_reg[k] <= valid_cur[k];
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k]  <= rem_next;
            root_reg[k] <= root_next;
            data_reg[k] <= data_cur[k] << 2;
            tag_reg[k]  <= tag_cur[k];
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_tag   = tag_reg[ROOT_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/varu_div_lane.sv =====
`default_nettype none
// One divider lane: unsigned restoring division, one quotient bit per stage.
module varu_div_lane
#(
    parameter int NUM_W = 32,
    parameter int DEN_W = 25,
    parameter int TAG_W = 8
)
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic [NUM_W-1:0] quo,
    output logic [TAG_W-1:0] tag_out
);

    logic [DEN_W-1:0] rem_reg [NUM_W];
    logic [NUM_W-1:0] nq_reg  [NUM_W];
    logic [DEN_W-1:0] den_reg [NUM_W];
    logic [TAG_W-1:0] tag_reg [NUM_W];

    logic [DEN_W-1:0] rem_cur [NUM_W];
    logic [NUM_W-1:0] nq_cur  [NUM_W];
    logic [DEN_W-1:0] den_cur [NUM_W];
    logic [TAG_W-1:0] tag_cur [NUM_W];

    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic [DEN_W:0]   part;
        logic [DEN_W-1:0] rem_next;
        logic             q_bit;

        if (k == 0)
        begin : g_first
            assign rem_cur[k] = '0;
            assign nq_cur[k]  = num;
            assign den_cur[k] = den;
            assign tag_cur[k] = tag_in;
        end
        else
        begin : g_rest
            assign rem_cur[k] = rem_reg[k-1];
            assign nq_cur[k]  = nq_reg[k-1];
            assign den_cur[k] = den_reg[k-1];
            assign tag_cur[k] = tag_reg[k-1];
        end

        always_comb
        begin
            part = {rem_cur[k], nq_cur[k][NUM_W-1]};
            if (part >= {1'b0, den_cur[k]})
            begin
                rem_next = DEN_W'(part - {1'b0, den_cur[k]});
                q_bit    = 1'b1;
            end
            else
            begin
                rem_next = DEN_W'(part);
                q_bit    = 1'b0;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            nq_reg[k]  <= {nq_cur[k][NUM_W-2:0], q_bit};
            den_reg[k] <= den_cur[k];
            tag_reg[k] <= tag_cur[k];
        end
    end

    assign quo     = nq_reg[NUM_W-1];
    assign tag_out = tag_reg[NUM_W-1];

endmodule
`default_nettype wire

// ===== rtl/core/vec4_arithmetic_unit_top.sv =====
// Channel   Handshake           Payload
// -------   ---------           -------
// command   start / busy        mode, a_x..a_w, b_x..b_w, scalar_in
// result    done (one cycle)    r_x..r_w, scalar_out, compare_code, status
//
// A command transfer happens at every rising edge with start high; busy is
// always low, so a new vector can be issued every cycle.
// Each result passes through these stages after its command:
// three front stages, 25 square root stages, one divider setup stage, one
// stage per quotient bit in the divider lanes, and the output register.
// Reset clears only the valid bits of the pipeline; no clearing pass is needed.
// The receiver cannot stall, so results leave in command order, spaced as their commands were.
`default_nettype none
`include "assert_macros.svh"
module vec4_arithmetic_unit_top
    import varu_pkg::*;
#(
    parameter int COMP_WIDTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   mode,
    input  logic signed [COMP_WIDTH-1:0] a_x,
    input  logic signed [COMP_WIDTH-1:0] a_y,
    input  logic signed [COMP_WIDTH-1:0] a_z,
    input  logic signed [COMP_WIDTH-1:0] a_w,
    input  logic signed [COMP_WIDTH-1:0] b_x,
    input  logic signed [COMP_WIDTH-1:0] b_y,
    input  logic signed [COMP_WIDTH-1:0] b_z,
    input  logic signed [COMP_WIDTH-1:0] b_w,
    input  logic signed [COMP_WIDTH-1:0] scalar_in,
    output logic                         done,
    output logic signed [COMP_WIDTH-1:0] r_x,
    output logic signed [COMP_WIDTH-1:0] r_y,
    output logic signed [COMP_WIDTH-1:0] r_z,
    output logic signed [COMP_WIDTH-1:0] r_w,
    output logic [SQ_W-1:0]              scalar_out,
    output logic [1:0]                   compare_code,
    output logic [1:0]                   status
);

    localparam int W       = COMP_WIDTH;
    // Widest dividend is a component times 2^16 (normalize).
    localparam int NUM_W   = W + NORM_SHIFT;
    // Divisor is a component, the scalar or the vector length.
    localparam int DEN_W   = (W > ROOT_W) ? W : ROOT_W;
    localparam int SQP_W   = 2 * W;
    localparam int SUM_W   = 2 * W + 2;
    localparam int SQX_W   = (SUM_W > SQ_W + 1) ? SUM_W : SQ_W + 1;
    localparam int WIDE_W  = 2 * W + 1;
    localparam int LATENCY = 3 + ROOT_W + 1 + NUM_W + 1;

    localparam logic signed [W-1:0]      CMAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0]      CMIN    = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [WIDE_W-1:0] WMAX    = WIDE_W'(CMAX);
    localparam logic signed [WIDE_W-1:0] WMIN    = WIDE_W'(CMIN);
    localparam logic signed [WIDE_W-1:0] ROUND_K = WIDE_W'(2 ** (FRAC_BITS - 1));
    localparam logic [NUM_W-1:0]         Q_LIM   = NUM_W'(1) << (W - 1);

    // Everything an item needs on its way through the square root.
    typedef struct packed {
        logic [3:0]          mode;
        logic [3:0][W-1:0]   a;
        logic [W-1:0]        s;
        logic [3:0][W-1:0]   rs;
        logic                sat;
        logic [SQ_W-1:0]     sq;
        logic                sum_zero;
        logic [1:0]          cmp;
    } sq_tag_t;

    // Per-lane side information that travels with the divider.
    typedef struct packed {
        logic         use_div;
        logic         neg;
        logic         dz;
        logic         num_pos;
        logic         num_neg;
        logic [W-1:0] r_pre;
    } lane_tag_t;

    // Item-wide results that wait beside the divider lanes.
    typedef struct packed {
        logic [SQ_W-1:0] sc;
        logic [1:0]      cmp;
        logic            sat;
    } shared_t;

    localparam int SQ_TAG_W   = $bits(sq_tag_t);
    localparam int LANE_TAG_W = $bits(lane_tag_t);

    function automatic logic [W-1:0] clamp_c(input logic signed [WIDE_W-1:0] v);
        logic [W-1:0] res;
        if (v > WMAX)
        begin
            res = CMAX;
        end
        else if (v < WMIN)
        begin
            res = CMIN;
        end
        else
        begin
            res = v[W-1:0];
        end
        return res;
    endfunction

    function automatic logic over_c(input logic signed [WIDE_W-1:0] v);
        return (v > WMAX) || (v < WMIN);
    endfunction

    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 1: command register.
    // ------------------------------------------------------------------
    logic                v1_reg;
    logic [3:0]          mode1_reg;
    logic signed [W-1:0] a1_reg [4];
    logic signed [W-1:0] b1_reg [4];
    logic signed [W-1:0] s1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        a1_reg[0] <= a_x;
        a1_reg[1] <= a_y;
        a1_reg[2] <= a_z;
        a1_reg[3] <= a_w;
        b1_reg[0] <= b_x;
        b1_reg[1] <= b_y;
        b1_reg[2] <= b_z;
        b1_reg[3] <= b_w;
        s1_reg    <= scalar_in;
    end

    // ------------------------------------------------------------------
    // Stage 2: one multiplier per product and lane, plus add, sub and negate.
    // ------------------------------------------------------------------
    logic                   v2_reg;
    logic [3:0]             mode2_reg;
    logic signed [W-1:0]    a2_reg    [4];
    logic signed [W-1:0]    s2_reg;
    logic [SQP_W-1:0]       sqa2_reg  [4];
    logic [SQP_W-1:0]       sqb2_reg  [4];
    logic signed [SQP_W-1:0] prod2_reg [4];
    logic [W-1:0]           rs2_reg   [4];
    logic                   sat2_reg;

    logic [SQP_W-1:0]        sqa2_next  [4];
    logic [SQP_W-1:0]        sqb2_next  [4];
    logic signed [SQP_W-1:0] prod2_next [4];
    logic [W-1:0]            rs2_next   [4];
    logic                    sat2_next;
    logic signed [WIDE_W-1:0] simple_v  [4];

    always_comb
    begin
        sat2_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            sqa2_next[i]  = $unsigned(SQP_W'(a1_reg[i] * a1_reg[i]));
            sqb2_next[i]  = $unsigned(SQP_W'(b1_reg[i] * b1_reg[i]));
            prod2_next[i] = SQP_W'(a1_reg[i] * s1_reg);
            case (mode1_reg)
                MODE_ADD: simple_v[i] = WIDE_W'(a1_reg[i]) + WIDE_W'(b1_reg[i]);
                MODE_SUB: simple_v[i] = WIDE_W'(a1_reg[i]) - WIDE_W'(b1_reg[i]);
                MODE_NEG: simple_v[i] = -WIDE_W'(a1_reg[i]);
                default:  simple_v[i] = '0;
            endcase
            rs2_next[i] = clamp_c(simple_v[i]);
            sat2_next   = sat2_next | over_c(simple_v[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode2_reg <= mode1_reg;
        s2_reg    <= s1_reg;
        sat2_reg  <= sat2_next;
        for (int i = 0; i < 4; i++)
        begin
            a2_reg[i]    <= a1_reg[i];
            sqa2_reg[i]  <= sqa2_next[i];
            sqb2_reg[i]  <= sqb2_next[i];
            prod2_reg[i] <= prod2_next[i];
            rs2_reg[i]   <= rs2_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sums of squares, compare, scale rounding, capped squared length.
    // ------------------------------------------------------------------
    logic                     v3_reg;
    sq_tag_t                  tag3_reg;
    sq_tag_t                  tag3_next;
    logic [SUM_W-1:0]         sum_a;
    logic [SUM_W-1:0]         sum_b;
    logic [SQX_W-1:0]         sum_ext;
    logic                     sq_over;
    logic signed [WIDE_W-1:0] scaled [4];
    logic                     scale_sat;

    always_comb
    begin
        sum_a = SUM_W'(sqa2_reg[0]) + SUM_W'(sqa2_reg[1])
              + SUM_W'(sqa2_reg[2]) + SUM_W'(sqa2_reg[3]);
        sum_b = SUM_W'(sqb2_reg[0]) + SUM_W'(sqb2_reg[1])
              + SUM_W'(sqb2_reg[2]) + SUM_W'(sqb2_reg[3]);
        sum_ext = SQX_W'(sum_a);
        sq_over = sum_ext > SQX_W'(SQ_CAP);

        scale_sat = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            scaled[i] = (WIDE_W'(prod2_reg[i]) + ROUND_K) >>> FRAC_BITS;
            scale_sat = scale_sat | over_c(scaled[i]);
        end

        tag3_next.mode     = mode2_reg;
        tag3_next.s        = s2_reg;
        tag3_next.sq       = sq_over ? SQ_CAP : SQ_W'(sum_ext);
        tag3_next.sum_zero = (sum_a == '0);
        for (int i = 0; i < 4; i++)
        begin
            tag3_next.a[i] = a2_reg[i];
        end

        case (mode2_reg)
            MODE_ADD, MODE_SUB, MODE_NEG:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    tag3_next.rs[i] = rs2_reg[i];
                end
                tag3_next.sat = sat2_reg;
            end
            MODE_SCALE:
            begin
                for (int i = 0; i < 4; i++)
                begin
                    tag3_next.rs[i] = clamp_c(scaled[i]);
                end
                tag3_next.sat = scale_sat;
            end
            MODE_LEN, MODE_SQLEN, MODE_NORM:
            begin
                tag3_next.rs  = '0;
                tag3_next.sat = sq_over;
            end
            default:
            begin
                tag3_next.rs  = '0;
                tag3_next.sat = 1'b0;
            end
        endcase

        if (mode2_reg != MODE_CMP)
        begin
            tag3_next.cmp = CMP_LESS;
        end
        else if (sum_a < sum_b)
        begin
            tag3_next.cmp = CMP_LESS;
        end
        else if (sum_a == sum_b)
        begin
            tag3_next.cmp = CMP_EQUAL;
        end
        else
        begin
            tag3_next.cmp = CMP_GREATER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        tag3_reg <= tag3_next;
    end

    // ------------------------------------------------------------------
    // Square root of the squared length in Q17.16, giving the length.
    // ------------------------------------------------------------------
    logic                v4;
    logic [ROOT_W-1:0]   root4;
    logic [SQ_TAG_W-1:0] tag4_vec;
    sq_tag_t             tag4;

    varu_sqrt_pipe #(
        .TAG_W (SQ_TAG_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_sq     (tag3_reg.sq),
        .in_tag    (tag3_reg),
        .out_valid (v4),
        .out_root  (root4),
        .out_tag   (tag4_vec)
    );

    assign tag4 = sq_tag_t'(tag4_vec);

    // ------------------------------------------------------------------
    // Divider setup: pick dividend and divisor per lane, split off signs.
    // ------------------------------------------------------------------
    logic signed [NUM_W-1:0] num4  [4];
    logic signed [DEN_W:0]   den4  [4];
    logic [NUM_W-1:0]        numm4 [4];
    logic [DEN_W-1:0]        denm4 [4];
    lane_tag_t               lt4   [4];
    shared_t                 sh4;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            num4[i]          = '0;
            den4[i]          = '0;
            lt4[i].use_div   = 1'b0;
            lt4[i].r_pre     = tag4.rs[i];
            case (tag4.mode)
                MODE_DIV:
                begin
                    num4[i]        = NUM_W'(signed'(tag4.a[i])) <<< FRAC_BITS;
                    den4[i]        = (DEN_W+1)'(signed'(tag4.s));
                    lt4[i].use_div = 1'b1;
                end
                MODE_RDIV:
                begin
                    num4[i]        = NUM_W'(signed'(tag4.s)) <<< FRAC_BITS;
                    den4[i]        = (DEN_W+1)'(signed'(tag4.a[i]));
                    lt4[i].use_div = 1'b1;
                end
                MODE_NORM:
                begin
                    num4[i]        = NUM_W'(signed'(tag4.a[i])) <<< NORM_SHIFT;
                    den4[i]        = $signed({1'b0, DEN_W'(root4)});
                    lt4[i].use_div = !tag4.sum_zero;
                    lt4[i].r_pre   = '0;
                end
                MODE_HOMOG:
                begin
                    num4[i]        = NUM_W'(signed'(tag4.a[i])) <<< FRAC_BITS;
                    den4[i]        = (DEN_W+1)'(signed'(tag4.a[3]));
                    lt4[i].use_div = (i != 3) && (tag4.a[3] != '0);
                    lt4[i].r_pre   = tag4.a[i];
                end
                default:
                begin
                    lt4[i].use_div = 1'b0;
                end
            endcase
            numm4[i]       = num4[i][NUM_W-1] ? NUM_W'(-num4[i]) : NUM_W'(num4[i]);
            denm4[i]       = den4[i][DEN_W] ? DEN_W'(-den4[i]) : DEN_W'(den4[i]);
            lt4[i].neg     = num4[i][NUM_W-1] ^ den4[i][DEN_W];
            lt4[i].dz      = lt4[i].use_div && (den4[i] == '0);
            lt4[i].num_neg = num4[i][NUM_W-1];
            lt4[i].num_pos = !num4[i][NUM_W-1] && (num4[i] != '0);
        end

        case (tag4.mode)
            MODE_LEN:   sh4.sc = SQ_W'(root4);
            MODE_SQLEN: sh4.sc = tag4.sq;
            default:    sh4.sc = '0;
        endcase
        sh4.cmp = tag4.cmp;
        sh4.sat = tag4.sat;
    end

    logic             v5_reg;
    logic [NUM_W-1:0] num5_reg [4];
    logic [DEN_W-1:0] den5_reg [4];
    lane_tag_t        lt5_reg  [4];
    shared_t          sh5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else
        begin
            v5_reg <= v4;
        end
    end

    always_ff @(posedge clk)
    begin
        sh5_reg <= sh4;
        for (int i = 0; i < 4; i++)
        begin
            num5_reg[i] <= numm4[i];
            den5_reg[i] <= denm4[i];
            lt5_reg[i]  <= lt4[i];
        end
    end

    // ------------------------------------------------------------------
    // Four divider lanes, with the item-wide results delayed beside them.
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]      quo6    [4];
    logic [LANE_TAG_W-1:0] lt6_vec [4];

    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        varu_div_lane #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W),
            .TAG_W (LANE_TAG_W)
        ) u_lane (
            .clk     (clk),
            .num     (num5_reg[g]),
            .den     (den5_reg[g]),
            .tag_in  (lt5_reg[g]),
            .quo     (quo6[g]),
            .tag_out (lt6_vec[g])
        );
    end

    logic    vd_reg  [NUM_W];
    shared_t shd_reg [NUM_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_W; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vd_reg[0] <= v5_reg;
            for (int k = 1; k < NUM_W; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        shd_reg[0] <= sh5_reg;
        for (int k = 1; k < NUM_W; k++)
        begin
            shd_reg[k] <= shd_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // Merge: signed saturation of each quotient and the common status.
    // ------------------------------------------------------------------
    lane_tag_t        lt6    [4];
    logic [NUM_W-1:0] qneg   [4];
    logic [W-1:0]     r_next [4];
    logic             any_sat;
    logic             any_dz;
    logic [1:0]       status_next;
    shared_t          shd_end;

    assign shd_end = shd_reg[NUM_W-1];

    always_comb
    begin
        any_sat = shd_end.sat;
        any_dz  = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            lt6[i]  = lane_tag_t'(lt6_vec[i]);
            qneg[i] = -quo6[i];
            if (!lt6[i].use_div)
            begin
                r_next[i] = lt6[i].r_pre;
            end
            else if (lt6[i].dz)
            begin
                any_dz = 1'b1;
                if (lt6[i].num_pos)
                begin
                    r_next[i] = CMAX;
                end
                else if (lt6[i].num_neg)
                begin
                    r_next[i] = CMIN;
                end
                else
                begin
                    r_next[i] = '0;
                end
            end
            else if (lt6[i].neg)
            begin
                if (quo6[i] > Q_LIM)
                begin
                    r_next[i] = CMIN;
                    any_sat   = 1'b1;
                end
                else
                begin
                    r_next[i] = qneg[i][W-1:0];
                end
            end
            else
            begin
                if (quo6[i] >= Q_LIM)
                begin
                    r_next[i] = CMAX;
                    any_sat   = 1'b1;
                end
                else
                begin
                    r_next[i] = quo6[i][W-1:0];
                end
            end
        end

        if (any_dz)
        begin
            status_next = ST_DIVZ;
        end
        else if (any_sat)
        begin
            status_next = ST_SAT;
        end
        else
        begin
            status_next = ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Output register: one result transfer per cycle with done set.
    // ------------------------------------------------------------------
    logic            done_reg;
    logic [W-1:0]    r_reg [4];
    logic [SQ_W-1:0] sc_reg;
    logic [1:0]      cmp_reg;
    logic [1:0]      status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vd_reg[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            r_reg[i] <= r_next[i];
        end
        sc_reg     <= shd_end.sc;
        cmp_reg    <= shd_end.cmp;
        status_reg <= status_next;
    end

    assign done         = done_reg;
    assign r_x          = r_reg[0];
    assign r_y          = r_reg[1];
    assign r_z          = r_reg[2];
    assign r_w          = r_reg[3];
    assign scalar_out   = sc_reg;
    assign compare_code = cmp_reg;
    assign status       = status_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Every result comes from an earlier matching command.
    `ASSERT_IMPLIES(a_fixed_latency, clk, rst_n, done, $past(start, LATENCY), "result without a matching command")
    // A length result carries no vector and no compare code.
    `ASSERT_IMPLIES(a_scalar_alone, clk, rst_n, done && (scalar_out != '0), (r_x == '0) && (r_y == '0) && (r_z == '0) && (r_w == '0) && (compare_code == CMP_LESS), "length result mixed with other fields")
    // A compare result reports no length, a zero x component and a clean status.
    `ASSERT_IMPLIES(a_compare_alone, clk, rst_n, done && (compare_code != CMP_LESS), (scalar_out == '0) && (status == ST_OK) && (r_x == '0), "compare result mixed with other fields")

endmodule
`default_nettype wire
